@@ design/qxmm_pkg.sv @@
// Shared constants, types and arithmetic helpers for the quad X-frame motor mixer.
`timescale 1ns / 1ps

package qxmm_pkg;

  // Field and datapath widths.
  localparam int unsigned ThrW    = 10;
  localparam int unsigned CmdW    = 11;
  localparam int unsigned PulseW  = 16;
  localparam int unsigned PosW    = 15;
  localparam int unsigned ProdW   = 31;
  localparam int unsigned RecipW  = 32;
  localparam int unsigned WideW   = 63;
  localparam int unsigned MotorN  = 4;
  localparam int unsigned InDataW = 56;
  localparam int unsigned OutDataW = 64;

  // Motor order inside the result item.
  localparam int unsigned MotorFl = 0;
  localparam int unsigned MotorFr = 1;
  localparam int unsigned MotorRr = 2;
  localparam int unsigned MotorRl = 3;

  // Command limits in tenths of a percent.
  localparam logic [ThrW-1:0]        ThrMax = 10'd1000;
  localparam logic signed [CmdW-1:0] CmdMax = 11'sd1000;
  localparam logic signed [CmdW-1:0] CmdMin = -11'sd1000;

  // Drive full scale in hundredths of a percent.
  localparam logic signed [15:0] FullScale = 16'sd10000;
  localparam logic signed [14:0] AdjMax    = 15'sd10000;
  localparam logic [PosW-1:0]    PosMax    = 15'd20000;

  // Division by 20000 as a multiply by ceil(2^46 / 20000) and a right shift by 46.
  // Exact for every product up to 65535 * 20000.
  localparam logic [RecipW-1:0] RecipK     = 32'd3518437209;
  localparam int unsigned       RecipShift = 46;

  // Configuration register indexes.
  localparam logic CfgPulseMin = 1'b0;
  localparam logic CfgPulseMax = 1'b1;

  // Reset values of the configuration registers.
  localparam logic [PulseW-1:0] PulseMinReset = 16'd1000;
  localparam logic [PulseW-1:0] PulseMaxReset = 16'd2000;

  // Stage load strobes handed to each motor lane.
  typedef struct packed {
    logic load_prod;
    logic load_quot;
    logic load_out;
  } lane_ctrl_t;

  // Saturate a signed command to plus or minus 1000.
  function automatic logic signed [CmdW-1:0] sat_cmd(input logic signed [CmdW-1:0] v);
    if (v > CmdMax) begin
      sat_cmd = CmdMax;
    end else if (v < CmdMin) begin
      sat_cmd = CmdMin;
    end else begin
      sat_cmd = v;
    end
  endfunction

  // Scale a saturated command by five (tenths to hundredths of the bipolar span).
  function automatic logic signed [13:0] times5(input logic signed [CmdW-1:0] v);
    logic signed [13:0] e;
    e = 14'(v);
    times5 = (e <<< 2) + e;
  endfunction

  // Sum the terms of one motor, clamp to full scale and shift to 0..20000.
  function automatic logic [PosW-1:0] motor_pos(input logic signed [15:0] term,
                                                input logic signed [13:0] a,
                                                input logic signed [13:0] b,
                                                input logic signed [13:0] c);
    logic signed [15:0] m;
    logic signed [15:0] mc;
    m = term + 16'(a) + 16'(b) + 16'(c);
    if (m > FullScale) begin
      mc = FullScale;
    end else if (m < -FullScale) begin
      mc = -FullScale;
    end else begin
      mc = m;
    end
    motor_pos = PosW'(mc + FullScale);
  endfunction

endpackage

@@ design/qxmm_motor_lane.sv @@
// One motor lane: scales the drive position by the pulse range and adds the minimum pulse.
`timescale 1ns / 1ps

module qxmm_motor_lane (
  input  logic                          clk,
  input  qxmm_pkg::lane_ctrl_t          ctrl,
  input  logic [qxmm_pkg::PosW-1:0]     pos,
  input  logic [qxmm_pkg::PulseW-1:0]   pulse_range,
  input  logic [qxmm_pkg::PulseW-1:0]   pulse_min,
  output logic [qxmm_pkg::PulseW-1:0]   pulse
);

  logic [qxmm_pkg::ProdW-1:0]  prod_r;
  logic [qxmm_pkg::ProdW-1:0]  prod_nxt;
  logic [qxmm_pkg::WideW-1:0]  recip_prod;
  logic [qxmm_pkg::PulseW-1:0] quot_r;
  logic [qxmm_pkg::PulseW-1:0] quot_nxt;
  logic [qxmm_pkg::PulseW-1:0] pulse_r;
  logic [qxmm_pkg::PulseW-1:0] pulse_nxt;

  // Range times position, at most 65535 * 20000.
  assign prod_nxt = qxmm_pkg::ProdW'(pulse_range) * qxmm_pkg::ProdW'(pos);

  // Floor of the product over 20000 by reciprocal multiply.
  assign recip_prod = qxmm_pkg::WideW'(prod_r) * qxmm_pkg::WideW'(qxmm_pkg::RecipK);
  assign quot_nxt   = recip_prod[qxmm_pkg::RecipShift +: qxmm_pkg::PulseW];

  // Offset by the minimum pulse, wrapping at 16 bits.
  assign pulse_nxt = quot_r + pulse_min;

  // Payload registers, loaded as the item moves down the pipeline.
  always_ff @(posedge clk) begin
    if (ctrl.load_prod) begin
      prod_r <= prod_nxt;
    end
    if (ctrl.load_quot) begin
      quot_r <= quot_nxt;
    end
    if (ctrl.load_out) begin
      pulse_r <= pulse_nxt;
    end
  end

  assign pulse = pulse_r;

endmodule

@@ design/quad_x_motor_mixer.sv @@
// Top level of the quad X-frame motor mixer: stream ports, mixing stage and four motor lanes.
`timescale 1ns / 1ps

// Mixes one command set (throttle, roll, pitch, yaw, altitude trim) into four motor pulse
// widths per item. The block takes one item every cycle while the output is not stalled,
// and each result passes through the input register, the mixing stage and the two
// multiplies of each motor lane (range times drive, then a reciprocal multiply for the
// division by 20000) followed by the output register.
// Each stage holds its item while the stage after it is full, so stalls at the output
// fill bubbles first and only then hold off the input. The user must write pulse_min and
// pulse_max through the cfg port while no item is in flight; the block does not enforce
// it. When pulse_max is below pulse_min every motor reports pulse_min.
module quad_x_motor_mixer (
  input  logic                            clk,
  input  logic                            rst_n,
  // Input items.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // in_tdata, from bit 0: throttle_cmd[9:0], roll_cmd[10:0], pitch_cmd[10:0],
  // yaw_cmd[10:0], height_trim[10:0], two zero bits.
  input  logic [qxmm_pkg::InDataW-1:0]    in_tdata,
  // Result items.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // out_tdata, from bit 0: front_left_pulse, front_right_pulse, rear_right_pulse,
  // rear_left_pulse, 16 bits each.
  output logic [qxmm_pkg::OutDataW-1:0]   out_tdata,
  // Configuration writes.
  input  logic                            cfg_wen,
  input  logic                            cfg_index,
  input  logic [qxmm_pkg::PulseW-1:0]     cfg_wdata
);

  // Configuration registers.
  logic [qxmm_pkg::PulseW-1:0] pulse_min_r;
  logic [qxmm_pkg::PulseW-1:0] pulse_max_r;

  // Stage valid bits: input, mix, product, quotient, output.
  logic v0_r, v1_r, v2_r, v3_r, v4_r;
  logic v0_nxt, v1_nxt, v2_nxt, v3_nxt, v4_nxt;
  logic load0, load1, load2, load3, load4;

  // Input register payload.
  logic [qxmm_pkg::ThrW-1:0]        thr_r;
  logic signed [qxmm_pkg::CmdW-1:0] roll_r;
  logic signed [qxmm_pkg::CmdW-1:0] pitch_r;
  logic signed [qxmm_pkg::CmdW-1:0] yaw_r;
  logic signed [qxmm_pkg::CmdW-1:0] trim_r;

  // Mixing logic.
  logic [qxmm_pkg::ThrW-1:0]        thr_sat;
  logic signed [qxmm_pkg::CmdW-1:0] trim_sat;
  logic signed [14:0]               adj_raw;
  logic [13:0]                      adj;
  logic signed [15:0]               term;
  logic signed [13:0]               roll5;
  logic signed [13:0]               pitch5;
  logic signed [13:0]               yaw5;
  logic [qxmm_pkg::PosW-1:0]        pos_nxt [qxmm_pkg::MotorN];
  logic [qxmm_pkg::PulseW-1:0]      range_nxt;

  // Mix stage registers.
  logic [qxmm_pkg::PosW-1:0]        pos_r [qxmm_pkg::MotorN];
  logic [qxmm_pkg::PulseW-1:0]      range_r;

  qxmm_pkg::lane_ctrl_t             lane_ctrl;
  logic [qxmm_pkg::PulseW-1:0]      pulse [qxmm_pkg::MotorN];

  // Configuration write port; an index outside the list has no register behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_min_r <= qxmm_pkg::PulseMinReset;
      pulse_max_r <= qxmm_pkg::PulseMaxReset;
    end else if (cfg_wen) begin
      case (cfg_index)
        qxmm_pkg::CfgPulseMin: pulse_min_r <= cfg_wdata;
        qxmm_pkg::CfgPulseMax: pulse_max_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Pipeline flow: a stage loads when the one before it holds an item and it is free.
  assign load4 = v3_r && (!v4_r || out_tready);
  assign load3 = v2_r && (!v3_r || load4);
  assign load2 = v1_r && (!v2_r || load3);
  assign load1 = v0_r && (!v1_r || load2);
  assign in_tready = !v0_r || load1;
  assign load0 = in_tvalid && in_tready;

  assign v0_nxt = load0 || (v0_r && !load1);
  assign v1_nxt = load1 || (v1_r && !load2);
  assign v2_nxt = load2 || (v2_r && !load3);
  assign v3_nxt = load3 || (v3_r && !load4);
  assign v4_nxt = load4 || (v4_r && !out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v0_r <= v0_nxt;
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
      v4_r <= v4_nxt;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (load0) begin
      thr_r   <= in_tdata[9:0];
      roll_r  <= in_tdata[20:10];
      pitch_r <= in_tdata[31:21];
      yaw_r   <= in_tdata[42:32];
      trim_r  <= in_tdata[53:43];
    end
  end

  // Saturate the commands and form the throttle term.
  always_comb begin
    thr_sat  = (thr_r > qxmm_pkg::ThrMax) ? qxmm_pkg::ThrMax : thr_r;
    trim_sat = qxmm_pkg::sat_cmd(trim_r);
    adj_raw  = signed'(15'(thr_sat)) * 15'sd10 + (15'(trim_sat) <<< 1);
    if (adj_raw < 15'sd0) begin
      adj = 14'd0;
    end else if (adj_raw > qxmm_pkg::AdjMax) begin
      adj = 14'(qxmm_pkg::AdjMax);
    end else begin
      adj = 14'(adj_raw);
    end
    term   = signed'({1'b0, adj, 1'b0}) - qxmm_pkg::FullScale;
    roll5  = qxmm_pkg::times5(qxmm_pkg::sat_cmd(roll_r));
    pitch5 = qxmm_pkg::times5(qxmm_pkg::sat_cmd(pitch_r));
    yaw5   = qxmm_pkg::times5(qxmm_pkg::sat_cmd(yaw_r));
  end

  // X-frame signs per motor, and the pulse range.
  assign pos_nxt[qxmm_pkg::MotorFl] = qxmm_pkg::motor_pos(term, pitch5, roll5, yaw5);
  assign pos_nxt[qxmm_pkg::MotorFr] = qxmm_pkg::motor_pos(term, pitch5, -roll5, -yaw5);
  assign pos_nxt[qxmm_pkg::MotorRr] = qxmm_pkg::motor_pos(term, -pitch5, -roll5, yaw5);
  assign pos_nxt[qxmm_pkg::MotorRl] = qxmm_pkg::motor_pos(term, -pitch5, roll5, -yaw5);
  assign range_nxt = (pulse_max_r >= pulse_min_r) ? (pulse_max_r - pulse_min_r) : '0;

  // Mix stage register.
  always_ff @(posedge clk) begin
    if (load1) begin
      pos_r   <= pos_nxt;
      range_r <= range_nxt;
    end
  end

  assign lane_ctrl.load_prod = load2;
  assign lane_ctrl.load_quot = load3;
  assign lane_ctrl.load_out  = load4;

  // One lane per motor.
  for (genvar g = 0; g < qxmm_pkg::MotorN; g++) begin : g_lane
    qxmm_motor_lane u_lane (
      .clk         (clk),
      .ctrl        (lane_ctrl),
      .pos         (pos_r[g]),
      .pulse_range (range_r),
      .pulse_min   (pulse_min_r),
      .pulse       (pulse[g])
    );
  end

  assign out_tvalid = v4_r;
  assign out_tdata  = {pulse[qxmm_pkg::MotorRl], pulse[qxmm_pkg::MotorRr],
                       pulse[qxmm_pkg::MotorFr], pulse[qxmm_pkg::MotorFl]};

`ifndef NO_ASSERTIONS
  // A full pipeline with a stalled output must hold off the input.
  a_full_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (v0_r && v1_r && v2_r && v3_r && v4_r && !out_tready) |-> !in_tready)
    else $error("input accepted while every stage is full and the output stalls");

  // An item waiting in the quotient stage moves into an empty output stage.
  a_no_output_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    (v3_r && !v4_r) |=> v4_r)
    else $error("output stage left empty behind a finished item");

  // Mixed drive positions never leave the 0..20000 span.
  a_pos_in_span: assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> (pos_r[0] <= qxmm_pkg::PosMax && pos_r[1] <= qxmm_pkg::PosMax &&
              pos_r[2] <= qxmm_pkg::PosMax && pos_r[3] <= qxmm_pkg::PosMax))
    else $error("motor drive position out of span");
`endif

endmodule

@@ dv/qxmm_checker.sv @@
// Checker for the quad X-frame motor mixer: predicts results from the ports and compares.
`timescale 1ns / 1ps

module qxmm_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  input  logic                          in_tready,
  // in_tdata, from bit 0: throttle_cmd, roll_cmd, pitch_cmd, yaw_cmd, height_trim, two zeros.
  input  logic [qxmm_pkg::InDataW-1:0]  in_tdata,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  // out_tdata, from bit 0: front_left, front_right, rear_right, rear_left pulses.
  input  logic [qxmm_pkg::OutDataW-1:0] out_tdata,
  input  logic                          cfg_wen,
  input  logic                          cfg_index,
  input  logic [qxmm_pkg::PulseW-1:0]   cfg_wdata,
  output int                            pending_cnt,
  output int                            fail_cnt
);
  import qxmm_pkg::*;

  localparam int DriveFull = 10000;
  localparam int RollLsb   = ThrW;
  localparam int PitchLsb  = ThrW + CmdW;
  localparam int YawLsb    = ThrW + 2 * CmdW;
  localparam int TrimLsb   = ThrW + 3 * CmdW;

  logic [PulseW-1:0]   lim_min_us;
  logic [PulseW-1:0]   lim_max_us;
  logic [OutDataW-1:0] pulse_q[$];
  int                  fails;

  initial begin
    pending_cnt = 0;
    fail_cnt    = 0;
    fails       = 0;
  end

  function automatic int clip(input int v, input int lo, input int hi);
    if (v < lo) begin
      return lo;
    end
    if (v > hi) begin
      return hi;
    end
    return v;
  endfunction

  // Mixes one command set into the four pulse widths under the given limits.
  function automatic logic [OutDataW-1:0] mix_pulses(input logic [InDataW-1:0] cmd,
                                                     input logic [PulseW-1:0] lo_us,
                                                     input logic [PulseW-1:0] hi_us);
    int                  thr;
    int                  roll;
    int                  pitch;
    int                  yaw;
    int                  trim;
    int                  adj;
    int                  term;
    int                  mix[MotorN];
    longint              span;
    longint              width_us;
    logic [OutDataW-1:0] res;
    thr   = int'(cmd[ThrW-1:0]);
    roll  = int'($signed(cmd[RollLsb +: CmdW]));
    pitch = int'($signed(cmd[PitchLsb +: CmdW]));
    yaw   = int'($signed(cmd[YawLsb +: CmdW]));
    trim  = int'($signed(cmd[TrimLsb +: CmdW]));
    // Saturate the commands, then scale tenths to hundredths.
    thr   = clip(thr, 0, 1000);
    roll  = 5 * clip(roll, -1000, 1000);
    pitch = 5 * clip(pitch, -1000, 1000);
    yaw   = 5 * clip(yaw, -1000, 1000);
    trim  = clip(trim, -1000, 1000);
    adj   = clip(thr * 10 + trim * 2, 0, DriveFull);
    term  = 2 * adj - DriveFull;
    // X-frame signs per motor.
    mix[MotorFl] = term + pitch + roll + yaw;
    mix[MotorFr] = term + pitch - roll - yaw;
    mix[MotorRr] = term - pitch - roll + yaw;
    mix[MotorRl] = term - pitch + roll - yaw;
    span = (hi_us >= lo_us) ? longint'(hi_us) - longint'(lo_us) : 0;
    for (int k = 0; k < MotorN; k++) begin
      width_us = longint'(lo_us) +
                 (span * (clip(mix[k], -DriveFull, DriveFull) + DriveFull)) / (2 * DriveFull);
      res[k*PulseW +: PulseW] = width_us[PulseW-1:0];
    end
    return res;
  endfunction

  // Result items are checked before the item accepted at the same edge is queued.
  always @(posedge clk) begin
    logic [OutDataW-1:0] want;
    string               motor_name[MotorN];
    motor_name[MotorFl] = "front_left";
    motor_name[MotorFr] = "front_right";
    motor_name[MotorRr] = "rear_right";
    motor_name[MotorRl] = "rear_left";
    if (!rst_n) begin
      lim_min_us = PulseMinReset;
      lim_max_us = PulseMaxReset;
      pulse_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (pulse_q.size() == 0) begin
          $display("%0t qxmm_checker: result %h arrived with none expected", $time, out_tdata);
          fails++;
        end else begin
          want = pulse_q.pop_front();
          for (int k = 0; k < MotorN; k++) begin
            if (out_tdata[k*PulseW +: PulseW] !== want[k*PulseW +: PulseW]) begin
              $display("%0t qxmm_checker: %s pulse expected %0d got %0d", $time,
                       motor_name[k], want[k*PulseW +: PulseW], out_tdata[k*PulseW +: PulseW]);
              fails++;
            end
          end
        end
      end
      if (cfg_wen) begin
        if (cfg_index == CfgPulseMin) begin
          lim_min_us = cfg_wdata;
        end else if (cfg_index == CfgPulseMax) begin
          lim_max_us = cfg_wdata;
        end
      end
      if (in_tvalid && in_tready) begin
        pulse_q.push_back(mix_pulses(in_tdata, lim_min_us, lim_max_us));
      end
    end
    pending_cnt <= pulse_q.size();
    fail_cnt    <= fails;
  end

endmodule

@@ dv/tb_quad_x_motor_mixer.sv @@
// Testbench top for the quad X-frame motor mixer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_quad_x_motor_mixer;
  import qxmm_pkg::*;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_tvalid = 1'b0;
  logic                in_tready;
  // Fields from bit 0: throttle_cmd, roll_cmd, pitch_cmd, yaw_cmd, height_trim, two zeros.
  logic [InDataW-1:0]  in_tdata = '0;
  logic                out_tvalid;
  logic                out_tready = 1'b0;
  // Fields from bit 0: front_left, front_right, rear_right, rear_left pulses.
  logic [OutDataW-1:0] out_tdata;
  logic                cfg_wen = 1'b0;
  logic                cfg_index = CfgPulseMin;
  logic [PulseW-1:0]   cfg_wdata = '0;
  int                  pending_cnt;
  int                  fail_cnt;
  int                  burst_left = 0;

  always #5 clk = ~clk;

  quad_x_motor_mixer u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  qxmm_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .cfg_wen     (cfg_wen),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .pending_cnt (pending_cnt),
    .fail_cnt    (fail_cnt)
  );

  // Packs one command set; negative values wrap into their two's complement fields.
  function automatic logic [InDataW-1:0] pack_cmd(input int thr, input int roll,
                                                  input int pitch, input int yaw,
                                                  input int trim);
    logic [ThrW-1:0] t;
    logic [CmdW-1:0] r;
    logic [CmdW-1:0] p;
    logic [CmdW-1:0] y;
    logic [CmdW-1:0] h;
    t = thr[ThrW-1:0];
    r = roll[CmdW-1:0];
    p = pitch[CmdW-1:0];
    y = yaw[CmdW-1:0];
    h = trim[CmdW-1:0];
    return {2'b00, h, y, p, r, t};
  endfunction

  // Mostly in-range axis commands, with some raw bit patterns and limit values.
  function automatic int rand_axis();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 2047);
      1: begin
        case ($urandom_range(0, 5))
          0: return 1000;
          1: return -1000;
          2: return 1023;
          3: return -1024;
          4: return 1001;
          default: return -1001;
        endcase
      end
      default: return int'($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  function automatic logic [InDataW-1:0] rand_cmd_word();
    int thr;
    thr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 1000);
    return pack_cmd(thr, rand_axis(), rand_axis(), rand_axis(), rand_axis());
  endfunction

  // Offers one item; bursts of random length are separated by random gaps.
  task automatic push_cmd(input logic [InDataW-1:0] cmd);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= cmd;
    do @(posedge clk); while (!in_tready);
    burst_left--;
  endtask

  task automatic write_reg(input logic idx, input logic [PulseW-1:0] val);
    cfg_index <= idx;
    cfg_wdata <= val;
    cfg_wen   <= 1'b1;
    @(posedge clk);
    cfg_wen   <= 1'b0;
    @(posedge clk);
  endtask

  // Waits until every expected result has arrived, then lets the pipeline settle.
  task automatic wait_drain();
    do @(negedge clk); while (pending_cnt != 0);
    repeat (10) @(posedge clk);
  endtask

  // Receiver: starts with a long hold-off so the pipeline fills, then mixes stall patterns.
  initial begin
    int n;
    do @(posedge clk); while (!rst_n);
    repeat (48) begin
      out_tready <= 1'b0;
      @(posedge clk);
    end
    forever begin
      case ($urandom_range(0, 15))
        0: begin
          n = $urandom_range(20, 40);
          repeat (n) begin
            out_tready <= 1'b0;
            @(posedge clk);
          end
        end
        1, 2, 3, 4, 5: begin
          n = $urandom_range(10, 40);
          repeat (n) begin
            out_tready <= 1'b1;
            @(posedge clk);
          end
        end
        6, 7, 8, 9, 10: begin
          n = $urandom_range(10, 30);
          repeat (n) begin
            out_tready <= 1'($urandom_range(0, 1));
            @(posedge clk);
          end
        end
        default: begin
          n = $urandom_range(4, 10);
          repeat (n) begin
            out_tready <= 1'b0;
            @(posedge clk);
            out_tready <= 1'b1;
            @(posedge clk);
            @(posedge clk);
          end
        end
      endcase
    end
  end

  // Stimulus and verdict.
  initial begin
    logic [PulseW-1:0] lo_us;
    logic [PulseW-1:0] hi_us;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed items under the reset limits: field extremes, each axis alone,
    // saturation of out-of-range commands, trim clamping and motor clamping.
    push_cmd(pack_cmd(0, 0, 0, 0, 0));
    push_cmd(pack_cmd(1000, 0, 0, 0, 0));
    push_cmd(pack_cmd(1023, 0, 0, 0, 0));
    push_cmd(pack_cmd(1001, 0, 0, 0, 0));
    push_cmd(pack_cmd(500, 1000, 0, 0, 0));
    push_cmd(pack_cmd(500, -1000, 0, 0, 0));
    push_cmd(pack_cmd(500, 0, 1000, 0, 0));
    push_cmd(pack_cmd(500, 0, -1000, 0, 0));
    push_cmd(pack_cmd(500, 0, 0, 1000, 0));
    push_cmd(pack_cmd(500, 0, 0, -1000, 0));
    push_cmd(pack_cmd(500, 1023, -1024, 1001, -1001));
    push_cmd(pack_cmd(500, -1024, 1023, -1001, 1001));
    push_cmd(pack_cmd(0, 0, 0, 0, -1024));
    push_cmd(pack_cmd(1000, 0, 0, 0, 1023));
    push_cmd(pack_cmd(0, 0, 0, 0, 1000));
    push_cmd(pack_cmd(1000, 0, 0, 0, -1000));
    push_cmd(pack_cmd(1000, 1000, 1000, 1000, 0));
    push_cmd(pack_cmd(0, -1000, -1000, -1000, 0));
    push_cmd(pack_cmd(500, 300, -200, 100, 50));
    push_cmd(pack_cmd(1023, 1023, 1023, 1023, 1023));
    push_cmd(pack_cmd(0, -1024, -1024, -1024, -1024));
    push_cmd(pack_cmd(1023, -1, -1, -1, -1));
    push_cmd(pack_cmd(341, 682, 1365, 682, 1365));
    in_tvalid <= 1'b0;
    wait_drain();

    // Random items under a series of limit settings, extremes and inverted ones included.
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: begin lo_us = 16'd0;     hi_us = 16'd65535; end
        1: begin lo_us = 16'd65535; hi_us = 16'd0;     end
        2: begin lo_us = 16'd1500;  hi_us = 16'd1500;  end
        3: begin lo_us = 16'd0;     hi_us = 16'd0;     end
        4: begin lo_us = 16'd65535; hi_us = 16'd65535; end
        7: begin
          lo_us = 16'($urandom_range(0, 2000));
          hi_us = lo_us + 16'($urandom_range(1, 3000));
        end
        8: begin lo_us = PulseMinReset; hi_us = PulseMaxReset; end
        default: begin
          lo_us = 16'($urandom_range(0, 65535));
          hi_us = 16'($urandom_range(0, 65535));
        end
      endcase
      write_reg(CfgPulseMin, lo_us);
      write_reg(CfgPulseMax, hi_us);
      repeat (105) push_cmd(rand_cmd_word());
      in_tvalid <= 1'b0;
      wait_drain();
    end

    if (fail_cnt == 0) begin
      $display("[quad_x_motor_mixer] OK");
    end else begin
      $display("[quad_x_motor_mixer] ERROR");
    end
    $finish;
  end

  // Run limit, far above the slowest correct run.
  initial begin
    #2_000_000;
    $display("[quad_x_motor_mixer] ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
design/qxmm_pkg.sv
design/qxmm_motor_lane.sv
design/quad_x_motor_mixer.sv
dv/qxmm_checker.sv
dv/tb_quad_x_motor_mixer.sv
